>>> sv/cmm_pkg.sv
// Shared constants, types and codes for the confusion matrix metrics block.
`timescale 1ns / 1ps
`default_nettype none
package cmm_pkg;
   localparam int MAX_CLASSES = 16;
   localparam int IDX_W = $clog2(MAX_CLASSES);
   localparam int CNT_W = IDX_W + 1;
   localparam int CELL_W = 16;
   localparam int SUM_W = 20;
   localparam int TOT_W = 24;
   localparam int FIX_W = 17;
   localparam int FRAC_W = 16;
   localparam int NUM_W = 40;
   localparam int DEN_W = 24;
   localparam int STEP_W = $clog2(NUM_W);
   localparam int FSUM_W = FIX_W + IDX_W;
   localparam int CLASS_RESET = 2;

   typedef enum logic [2:0] {
      OP_PREC,
      OP_REC,
      OP_F1,
      OP_OVERALL,
      OP_MACRO,
      OP_WEIGHTED,
      OP_HIT
   } cmm_op_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL,
      ST_ACC,
      ST_SUM,
      ST_EMIT
   } cmm_state_type;

   typedef struct packed {
      logic       load_phase;
      logic       load;
      logic       div_start;
      logic       capture;
      logic       mul;
      logic       acc;
      logic       sum;
      logic       emit;
      logic       clear;
      logic       k_zero;
      logic       k_inc;
      cmm_op_type op;
   } cmm_cmd_type;

   typedef struct packed {
      logic div_done;
      logic k_last;
      logic cell_last;
   } cmm_status_type;
endpackage
`default_nettype wire

>>> sv/cmm_divider.sv
// Restoring divider, one quotient bit per cycle, zero divisor gives zero.
`timescale 1ns / 1ps
`default_nettype none
module cmm_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [cmm_pkg::NUM_W-1:0] numerator,
   input  wire logic [cmm_pkg::DEN_W-1:0] denominator,
   output logic                           done,
   output logic [cmm_pkg::NUM_W-1:0]      quotient
);
   import cmm_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W:0]      trial;
   logic                fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = numerator;
         den_in = denominator;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = (den_ff == '0) ? '0 : quo_ff;
endmodule
`default_nettype wire

>>> sv/cmm_datapath.sv
// Accumulators, per-class stores, operand selection and result fields.
`timescale 1ns / 1ps
`default_nettype none
module cmm_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmm_pkg::cmm_cmd_type          cmd,
   output cmm_pkg::cmm_status_type            status,
   input  wire logic                          csr_write_enable,
   input  wire logic [cmm_pkg::CNT_W-1:0]     csr_write_data,
   input  wire logic [cmm_pkg::CELL_W-1:0]    req_cell_count,
   output logic [cmm_pkg::IDX_W-1:0]          rsp_class_index,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_precision,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_recall,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_f1_value,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_class_accuracy,
   output logic [cmm_pkg::SUM_W-1:0]          rsp_support,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_overall_accuracy,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_macro_f1,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_weighted_f1,
   output logic                               rsp_last
);
   import cmm_pkg::*;

   logic [CNT_W-1:0]  class_count_ff;
   logic [CNT_W-1:0]  n_act, n_m1;
   logic [SUM_W-1:0]  row_ff [MAX_CLASSES];
   logic [SUM_W-1:0]  col_ff [MAX_CLASSES];
   logic [CELL_W-1:0] diag_ff [MAX_CLASSES];
   logic [FIX_W-1:0]  prec_ff [MAX_CLASSES];
   logic [FIX_W-1:0]  rec_ff [MAX_CLASSES];
   logic [FIX_W-1:0]  f1_ff [MAX_CLASSES];
   logic [TOT_W-1:0]  total_ff, correct_ff;
   logic [IDX_W-1:0]  r_ff, c_ff, k_ff;
   logic [FIX_W-1:0]  p_ff, q_ff, f_ff, hit_ff;
   logic [2*FIX_W-1:0] pq_ff;
   logic [FIX_W+SUM_W-1:0] wprod_ff;
   logic [FSUM_W-1:0] fsum_ff;
   logic [NUM_W-1:0]  wsum_ff;
   logic [FIX_W-1:0]  overall_ff, macro_ff, weighted_ff;
   logic [IDX_W-1:0]  row_addr, col_addr;
   logic [SUM_W-1:0]  row_rd, col_rd;
   logic [CELL_W-1:0] tp;
   logic [TOT_W:0]    hit_wide;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [DEN_W-1:0]  div_den;
   logic              div_done;
   logic              clear_all;
   logic              k_last, cell_last;

   always_comb begin
      if (class_count_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (class_count_ff > CNT_W'(MAX_CLASSES)) begin
         n_act = CNT_W'(MAX_CLASSES);
      end else begin
         n_act = class_count_ff;
      end
      n_m1 = n_act - 1'b1;
   end

   assign row_addr = cmd.load_phase ? r_ff : k_ff;
   assign col_addr = cmd.load_phase ? c_ff : k_ff;
   assign row_rd = row_ff[row_addr];
   assign col_rd = col_ff[col_addr];
   assign tp = diag_ff[k_ff];
   assign hit_wide = {1'b0, total_ff} + {(TOT_W - CELL_W)'(0), tp, 1'b0}
                     - {5'd0, row_rd} - {5'd0, col_rd};
   assign clear_all = cmd.clear || csr_write_enable;

   always_comb begin
      div_num = '0;
      div_den = '0;
      case (cmd.op)
         OP_PREC: begin
            div_num = NUM_W'({tp, FRAC_W'(0)});
            div_den = DEN_W'(col_rd);
         end
         OP_REC: begin
            div_num = NUM_W'({tp, FRAC_W'(0)});
            div_den = DEN_W'(row_rd);
         end
         OP_F1: begin
            div_num = NUM_W'({pq_ff, 1'b0});
            div_den = DEN_W'({1'b0, p_ff} + {1'b0, q_ff});
         end
         OP_OVERALL: begin
            div_num = NUM_W'({correct_ff, FRAC_W'(0)});
            div_den = total_ff;
         end
         OP_MACRO: begin
            div_num = NUM_W'(fsum_ff);
            div_den = DEN_W'(n_act);
         end
         OP_WEIGHTED: begin
            div_num = wsum_ff;
            div_den = total_ff;
         end
         OP_HIT: begin
            div_num = NUM_W'({hit_wide[TOT_W-1:0], FRAC_W'(0)});
            div_den = total_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   cmm_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= CNT_W'(CLASS_RESET);
      end else if (csr_write_enable) begin
         class_count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < MAX_CLASSES; i++) begin
            row_ff[i] <= '0;
            col_ff[i] <= '0;
            diag_ff[i] <= '0;
         end
         total_ff <= '0;
         correct_ff <= '0;
         r_ff <= '0;
         c_ff <= '0;
         fsum_ff <= '0;
         wsum_ff <= '0;
      end else begin
         if (cmd.load) begin
            row_ff[row_addr] <= row_rd + SUM_W'(req_cell_count);
            col_ff[col_addr] <= col_rd + SUM_W'(req_cell_count);
            total_ff <= total_ff + TOT_W'(req_cell_count);
            if (r_ff == c_ff) begin
               diag_ff[r_ff] <= req_cell_count;
               correct_ff <= correct_ff + TOT_W'(req_cell_count);
            end
            if ({1'b0, c_ff} == n_m1) begin
               c_ff <= '0;
               r_ff <= r_ff + 1'b1;
            end else begin
               c_ff <= c_ff + 1'b1;
            end
         end
         if (cmd.acc) begin
            fsum_ff <= fsum_ff + FSUM_W'(f_ff);
         end
         if (cmd.sum) begin
            wsum_ff <= wsum_ff + NUM_W'(wprod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.k_zero) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         case (cmd.op)
            OP_PREC: begin
               prec_ff[k_ff] <= div_quo[FIX_W-1:0];
               p_ff <= div_quo[FIX_W-1:0];
            end
            OP_REC: begin
               rec_ff[k_ff] <= div_quo[FIX_W-1:0];
               q_ff <= div_quo[FIX_W-1:0];
            end
            OP_F1: begin
               f1_ff[k_ff] <= div_quo[FIX_W-1:0];
               f_ff <= div_quo[FIX_W-1:0];
            end
            OP_OVERALL:  overall_ff <= div_quo[FIX_W-1:0];
            OP_MACRO:    macro_ff <= div_quo[FIX_W-1:0];
            OP_WEIGHTED: weighted_ff <= div_quo[FIX_W-1:0];
            OP_HIT:      hit_ff <= div_quo[FIX_W-1:0];
            default:     hit_ff <= hit_ff;
         endcase
      end
      if (cmd.mul) begin
         pq_ff <= p_ff * q_ff;
      end
      if (cmd.acc) begin
         wprod_ff <= f_ff * row_rd;
      end
   end

   assign k_last = ({1'b0, k_ff} == n_m1);
   assign cell_last = ({1'b0, r_ff} == n_m1) && ({1'b0, c_ff} == n_m1);
   assign status = {div_done, k_last, cell_last};

   assign rsp_class_index = k_ff;
   assign rsp_precision = prec_ff[k_ff];
   assign rsp_recall = rec_ff[k_ff];
   assign rsp_f1_value = f1_ff[k_ff];
   assign rsp_class_accuracy = hit_ff;
   assign rsp_support = row_rd;
   assign rsp_overall_accuracy = overall_ff;
   assign rsp_macro_f1 = macro_ff;
   assign rsp_weighted_f1 = weighted_ff;
   assign rsp_last = k_last;
endmodule
`default_nettype wire

>>> sv/cmm_controller.sv
// Sequencer that loads cells and steps the per-class divisions and results.
`timescale 1ns / 1ps
`default_nettype none
module cmm_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output logic                         rsp_valid,
   input  wire cmm_pkg::cmm_status_type status,
   output cmm_pkg::cmm_cmd_type         cmd
);
   import cmm_pkg::*;

   cmm_state_type state_ff, state_in;
   cmm_op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         op_ff <= OP_PREC;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cmd = '0;
      cmd.op = op_ff;
      case (state_ff)
         ST_LOAD: begin
            cmd.load_phase = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               if (status.cell_last) begin
                  cmd.k_zero = 1'b1;
                  op_in = OP_PREC;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.capture = 1'b1;
               case (op_ff)
                  OP_PREC: begin
                     op_in = OP_REC;
                     state_in = ST_DIV_START;
                  end
                  OP_REC:      state_in = ST_MUL;
                  OP_F1:       state_in = ST_ACC;
                  OP_OVERALL: begin
                     op_in = OP_MACRO;
                     state_in = ST_DIV_START;
                  end
                  OP_MACRO: begin
                     op_in = OP_WEIGHTED;
                     state_in = ST_DIV_START;
                  end
                  OP_WEIGHTED: begin
                     op_in = OP_HIT;
                     cmd.k_zero = 1'b1;
                     state_in = ST_DIV_START;
                  end
                  OP_HIT:      state_in = ST_EMIT;
                  default:     state_in = ST_LOAD;
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            op_in = OP_F1;
            state_in = ST_DIV_START;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            state_in = ST_DIV_START;
            if (status.k_last) begin
               op_in = OP_OVERALL;
            end else begin
               cmd.k_inc = 1'b1;
               op_in = OP_PREC;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.k_last) begin
               cmd.clear = 1'b1;
               state_in = ST_LOAD;
            end else begin
               cmd.k_inc = 1'b1;
               op_in = OP_HIT;
               state_in = ST_DIV_START;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign busy = (state_ff != ST_LOAD);
   assign rsp_valid = cmd.emit;

`ifndef NO_ASSERTIONS
   a_start_single: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start)
      else $error("divider start lasted more than one cycle");
   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT && !status.div_done) |=> (state_ff == ST_DIV_WAIT))
      else $error("left the division wait early");
   a_emit_after_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_DIV_WAIT && op_ff == OP_HIT))
      else $error("result emitted without a class accuracy division");
`endif
endmodule
`default_nettype wire

>>> sv/confusion_matrix_metrics.sv
// Top level of the confusion matrix metrics block.
`timescale 1ns / 1ps
`default_nettype none
// Cells are taken one per cycle while busy is low and start is high, row-major with
// true classes as rows. After the last cell busy rises and the block computes, for each
// class, precision, recall and F1 (three divisions) and then overall accuracy, macro F1
// and weighted F1 (three more), and finally class accuracy per class (one division
// each). All divisions share one divider. Each result is shown for exactly one cycle
// on rsp_valid and the receiver cannot stall it; rsp_last marks the final class.
module confusion_matrix_metrics (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [cmm_pkg::CELL_W-1:0]    req_cell_count,
   input  wire logic                          csr_write_enable,
   input  wire logic [cmm_pkg::CNT_W-1:0]     csr_write_data,
   output logic                               rsp_valid,
   output logic [cmm_pkg::IDX_W-1:0]          rsp_class_index,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_precision,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_recall,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_f1_value,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_class_accuracy,
   output logic [cmm_pkg::SUM_W-1:0]          rsp_support,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_overall_accuracy,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_macro_f1,
   output logic [cmm_pkg::FIX_W-1:0]          rsp_weighted_f1,
   output logic                               rsp_last
);
   import cmm_pkg::*;

   cmm_cmd_type    cmd;
   cmm_status_type status;

   cmm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   cmm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_cell_count       (req_cell_count),
      .rsp_class_index      (rsp_class_index),
      .rsp_precision        (rsp_precision),
      .rsp_recall           (rsp_recall),
      .rsp_f1_value         (rsp_f1_value),
      .rsp_class_accuracy   (rsp_class_accuracy),
      .rsp_support          (rsp_support),
      .rsp_overall_accuracy (rsp_overall_accuracy),
      .rsp_macro_f1         (rsp_macro_f1),
      .rsp_weighted_f1      (rsp_weighted_f1),
      .rsp_last             (rsp_last)
   );
endmodule
`default_nettype wire
